// File: rtl/mqf_pkg.sv
// Shared constants, types and helper functions of the multi-queue fan-out block.
package mqf_pkg;

	// Sizing of the queue set and of the frame word.
	localparam int NUM_TARGETS = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int FRAME_WIDTH = 32;

	// Derived widths.
	localparam int TIDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
	localparam int CNT_W  = $clog2(NUM_TARGETS + 1);
	localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS  = NUM_TARGETS * QUEUE_DEPTH;
	localparam int FA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SUM_W  = $clog2(NUM_TARGETS * (QUEUE_DEPTH + 1) + 1);

	// Fixed field widths of the ports.
	localparam int ACT_W       = 2;
	localparam int TGT_W       = 3;
	localparam int TCNT_W      = 4;
	localparam int MASK_W      = 8;
	localparam int MASK_IDX_W  = $clog2(MASK_W);
	localparam int CAP_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int DROP_W      = 8;
	localparam int DROP_MAX    = 255;
	localparam int TOTAL_W     = 32;
	localparam int DEPTH_W     = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH,
		ACT_POP,
		ACT_CLOSE,
		ACT_QUERY
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FANOUT_MODE,
		CFG_TARGET_COUNT,
		CFG_SUBSET_MASK,
		CFG_CAPACITY
	} cfg_idx_t;

	typedef struct packed {
		logic              fanout_mode;
		logic [TCNT_W-1:0] target_count;
		logic [MASK_W-1:0] subset_mask;
		logic [CAP_W-1:0]  capacity;
	} cfg_t;

	// One queue descriptor: read pointer and number of frames held.
	typedef struct packed {
		logic [HEAD_W-1:0] head;
		logic [FILL_W-1:0] fill;
	} desc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_LOOK,
		ST_DESC,
		ST_FRAME
	} state_t;

	// Ring position plus offset, with offset at most one full lap.
	function automatic logic [HEAD_W-1:0] wrap_add(input logic [HEAD_W-1:0] h,
			input logic [FILL_W-1:0] off);
		logic [FILL_W:0] s;
		s = (FILL_W + 1)'(h) + (FILL_W + 1)'(off);
		if (s >= (FILL_W + 1)'(QUEUE_DEPTH)) begin
			s = s - (FILL_W + 1)'(QUEUE_DEPTH);
		end
		return HEAD_W'(s);
	endfunction

	// Frame store address of a ring position inside one queue's region.
	function automatic logic [FA_W-1:0] slot_addr(input logic [TIDX_W-1:0] q,
			input logic [HEAD_W-1:0] pos);
		return FA_W'(int'(q) * QUEUE_DEPTH + int'(pos));
	endfunction

endpackage

// File: rtl/multi_queue_fanout_drop_oldest.sv
// Top level of the multi-queue fan-out block with drop-oldest overflow.
// From accept to done: a depth query, half close or closed push passes through the lookup
// and descriptor states, a pop that returns a frame adds the frame state, and an open push
// first sweeps its configured targets in the push state.
// A push visits each configured target once, one descriptor read-modify-write per cycle.
// A new word may be started in the cycle that done is high; results cannot be stalled.
// Reset is asynchronous: queues empty, block open, drop total zero, registers at defaults.
module multi_queue_fanout_drop_oldest (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [mqf_pkg::ACT_W-1:0]       action,
	input  logic [mqf_pkg::TGT_W-1:0]       target,
	input  logic [mqf_pkg::FRAME_WIDTH-1:0] frame_word,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mqf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mqf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            done,
	output logic                            pop_valid,
	output logic [mqf_pkg::FRAME_WIDTH-1:0] frame_out,
	output logic [mqf_pkg::DROP_W-1:0]      dropped_now,
	output logic [mqf_pkg::TOTAL_W-1:0]     total_dropped,
	output logic [mqf_pkg::DEPTH_W-1:0]     target_depth,
	output logic                            closed
);

	mqf_pkg::cfg_t                   cfg;
	logic                            d_we;
	logic [mqf_pkg::TIDX_W-1:0]      d_waddr;
	mqf_pkg::desc_t                  d_wdata;
	logic [mqf_pkg::TIDX_W-1:0]      d_raddr;
	mqf_pkg::desc_t                  d_rdata;
	logic                            f_we;
	logic [mqf_pkg::FA_W-1:0]        f_waddr;
	logic [mqf_pkg::FRAME_WIDTH-1:0] f_wdata;
	logic [mqf_pkg::FA_W-1:0]        f_raddr;
	logic [mqf_pkg::FRAME_WIDTH-1:0] f_rdata;

	// Configuration registers.
	mqf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer.
	mqf_ctl u_ctl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.target        (target),
		.frame_word    (frame_word),
		.done          (done),
		.pop_valid     (pop_valid),
		.frame_out     (frame_out),
		.dropped_now   (dropped_now),
		.total_dropped (total_dropped),
		.target_depth  (target_depth),
		.closed        (closed),
		.d_we          (d_we),
		.d_waddr       (d_waddr),
		.d_wdata       (d_wdata),
		.d_raddr       (d_raddr),
		.d_rdata       (d_rdata),
		.f_we          (f_we),
		.f_waddr       (f_waddr),
		.f_wdata       (f_wdata),
		.f_raddr       (f_raddr),
		.f_rdata       (f_rdata)
	);

	// Queue descriptors, one per target.
	mqf_ram #(
		.WIDTH ($bits(mqf_pkg::desc_t)),
		.DEPTH (mqf_pkg::NUM_TARGETS)
	) u_desc_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// Frame store, one ring region per target.
	mqf_ram #(
		.WIDTH (mqf_pkg::FRAME_WIDTH),
		.DEPTH (mqf_pkg::SLOTS)
	) u_frame_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

endmodule

// File: rtl/mqf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mqf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/mqf_cfg.sv
// Configuration register file of the multi-queue fan-out block.
module mqf_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mqf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mqf_pkg::CFG_DATA_W-1:0] cfg_data,
	output mqf_pkg::cfg_t                  cfg
);

	mqf_pkg::cfg_t cfg_q;

	// Every write word is taken at once.
	assign cfg_ready = 1'b1;

	// Register writes by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fanout_mode  <= 1'b1;
			cfg_q.target_count <= mqf_pkg::TCNT_W'(8);
			cfg_q.subset_mask  <= '0;
			cfg_q.capacity     <= mqf_pkg::CAP_W'(16);
		end else if (cfg_valid) begin
			case (mqf_pkg::cfg_idx_t'(cfg_index))
				mqf_pkg::CFG_FANOUT_MODE: begin
					cfg_q.fanout_mode <= cfg_data[0];
				end
				mqf_pkg::CFG_TARGET_COUNT: begin
					cfg_q.target_count <= cfg_data[mqf_pkg::TCNT_W-1:0];
				end
				mqf_pkg::CFG_SUBSET_MASK: begin
					cfg_q.subset_mask <= cfg_data[mqf_pkg::MASK_W-1:0];
				end
				mqf_pkg::CFG_CAPACITY: begin
					cfg_q.capacity <= cfg_data[mqf_pkg::CAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/mqf_ctl.sv
// Sequencer and read-modify-write datapath over the descriptor and frame memories.
module mqf_ctl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mqf_pkg::cfg_t                    cfg,
	input  logic                             start,
	output logic                             busy,
	input  logic [mqf_pkg::ACT_W-1:0]        action,
	input  logic [mqf_pkg::TGT_W-1:0]        target,
	input  logic [mqf_pkg::FRAME_WIDTH-1:0]  frame_word,
	output logic                             done,
	output logic                             pop_valid,
	output logic [mqf_pkg::FRAME_WIDTH-1:0]  frame_out,
	output logic [mqf_pkg::DROP_W-1:0]       dropped_now,
	output logic [mqf_pkg::TOTAL_W-1:0]      total_dropped,
	output logic [mqf_pkg::DEPTH_W-1:0]      target_depth,
	output logic                             closed,
	// Descriptor memory port
	output logic                             d_we,
	output logic [mqf_pkg::TIDX_W-1:0]       d_waddr,
	output mqf_pkg::desc_t                   d_wdata,
	output logic [mqf_pkg::TIDX_W-1:0]       d_raddr,
	input  mqf_pkg::desc_t                   d_rdata,
	// Frame memory port
	output logic                             f_we,
	output logic [mqf_pkg::FA_W-1:0]         f_waddr,
	output logic [mqf_pkg::FRAME_WIDTH-1:0]  f_wdata,
	output logic [mqf_pkg::FA_W-1:0]         f_raddr,
	input  logic [mqf_pkg::FRAME_WIDTH-1:0]  f_rdata
);

	mqf_pkg::state_t state_q, state_d;

	// Latched item.
	mqf_pkg::action_t                  act_q;
	logic [mqf_pkg::TGT_W-1:0]         tgt_q;
	logic [mqf_pkg::FRAME_WIDTH-1:0]   word_q;

	// Push sweep: read counter and the stage that holds returned descriptors.
	logic [mqf_pkg::CNT_W-1:0]         rd_q_q;
	logic                              push_v_s1;
	logic [mqf_pkg::TIDX_W-1:0]        push_q_s1;
	logic                              desc_hit_s1;
	logic [mqf_pkg::NUM_TARGETS-1:0]   desc_vld_q;

	logic [mqf_pkg::SUM_W-1:0]         drop_sum_q;
	logic [mqf_pkg::TOTAL_W-1:0]       total_q;
	logic                              closed_q;

	// Result registers.
	logic                              done_q;
	logic                              pop_valid_q;
	logic [mqf_pkg::FRAME_WIDTH-1:0]   frame_out_q;
	logic [mqf_pkg::DROP_W-1:0]        drop_now_q;
	logic [mqf_pkg::DEPTH_W-1:0]       depth_q;

	logic                              accept;
	logic                              issue;
	logic                              push_end;
	logic [mqf_pkg::CNT_W-1:0]         count_eff;
	logic [mqf_pkg::FILL_W-1:0]        cap_eff;
	logic                              known;
	logic [mqf_pkg::TIDX_W-1:0]        tgt_idx;
	mqf_pkg::desc_t                    cur;
	logic                              sel;
	logic                              full;
	logic [mqf_pkg::HEAD_W-1:0]        wpos;
	logic [mqf_pkg::FILL_W-1:0]        fill1;
	logic [mqf_pkg::HEAD_W-1:0]        head1;
	logic [mqf_pkg::FILL_W-1:0]        excess;
	logic [mqf_pkg::FILL_W:0]          q_drop;
	mqf_pkg::desc_t                    push_desc;
	mqf_pkg::desc_t                    pop_desc;
	logic                              pop_hit;
	logic [mqf_pkg::DROP_W-1:0]        drop_sat;
	logic [mqf_pkg::TOTAL_W:0]         total_sum;

	// Effective configuration and addressed target.
	always_comb begin
		if (int'(cfg.target_count) > mqf_pkg::NUM_TARGETS) begin
			count_eff = mqf_pkg::CNT_W'(mqf_pkg::NUM_TARGETS);
		end else begin
			count_eff = mqf_pkg::CNT_W'(cfg.target_count);
		end
		if (int'(cfg.capacity) > mqf_pkg::QUEUE_DEPTH) begin
			cap_eff = mqf_pkg::FILL_W'(mqf_pkg::QUEUE_DEPTH);
		end else begin
			cap_eff = mqf_pkg::FILL_W'(cfg.capacity);
		end
	end

	assign known   = int'(tgt_q) < int'(count_eff);
	assign tgt_idx = mqf_pkg::TIDX_W'(tgt_q);
	assign accept  = start && (state_q == mqf_pkg::ST_IDLE);
	assign issue   = (state_q == mqf_pkg::ST_PUSH) && (rd_q_q < count_eff);
	assign push_end = (state_q == mqf_pkg::ST_PUSH) && !issue && !push_v_s1;

	// A descriptor never written reads as an empty queue at ring position zero.
	assign cur = desc_hit_s1 ? d_rdata : '0;

	// Write-set membership of the queue in the push stage.
	assign sel = cfg.fanout_mode ||
		((int'(push_q_s1) < mqf_pkg::MASK_W) &&
		cfg.subset_mask[mqf_pkg::MASK_IDX_W'(push_q_s1)]);

	// Append one frame, then trim the queue down to the capacity.
	always_comb begin
		full   = (cur.fill == mqf_pkg::FILL_W'(mqf_pkg::QUEUE_DEPTH));
		wpos   = mqf_pkg::wrap_add(cur.head, full ? '0 : cur.fill);
		fill1  = full ? cur.fill : cur.fill + mqf_pkg::FILL_W'(1);
		head1  = full ? mqf_pkg::wrap_add(cur.head, mqf_pkg::FILL_W'(1)) : cur.head;
		excess = (fill1 > cap_eff) ? fill1 - cap_eff : '0;
		push_desc.head = mqf_pkg::wrap_add(head1, excess);
		push_desc.fill = fill1 - excess;
		q_drop = (mqf_pkg::FILL_W + 1)'(excess) + (mqf_pkg::FILL_W + 1)'(full);
	end

	// Pop: consume the head entry of a known, non-empty queue.
	assign pop_hit = (act_q == mqf_pkg::ACT_POP) && known && (cur.fill != '0);
	assign pop_desc.head = mqf_pkg::wrap_add(cur.head, mqf_pkg::FILL_W'(1));
	assign pop_desc.fill = cur.fill - mqf_pkg::FILL_W'(1);

	// Saturated drop figures.
	assign drop_sat = (int'(drop_sum_q) > mqf_pkg::DROP_MAX) ?
		mqf_pkg::DROP_W'(mqf_pkg::DROP_MAX) : mqf_pkg::DROP_W'(drop_sum_q);
	assign total_sum = {1'b0, total_q} + (mqf_pkg::TOTAL_W + 1)'(drop_sum_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mqf_pkg::ST_IDLE: begin
				if (accept) begin
					if ((mqf_pkg::action_t'(action) == mqf_pkg::ACT_PUSH) && !closed_q) begin
						state_d = mqf_pkg::ST_PUSH;
					end else begin
						state_d = mqf_pkg::ST_LOOK;
					end
				end
			end
			mqf_pkg::ST_PUSH: begin
				if (push_end) begin
					state_d = mqf_pkg::ST_LOOK;
				end
			end
			mqf_pkg::ST_LOOK: begin
				state_d = mqf_pkg::ST_DESC;
			end
			mqf_pkg::ST_DESC: begin
				state_d = pop_hit ? mqf_pkg::ST_FRAME : mqf_pkg::ST_IDLE;
			end
			mqf_pkg::ST_FRAME: begin
				state_d = mqf_pkg::ST_IDLE;
			end
			default: begin
				state_d = mqf_pkg::ST_IDLE;
			end
		endcase
	end

	// Memory port controls.
	always_comb begin
		d_raddr = (state_q == mqf_pkg::ST_PUSH) ? mqf_pkg::TIDX_W'(rd_q_q) : tgt_idx;
		d_we    = 1'b0;
		d_waddr = tgt_idx;
		d_wdata = pop_desc;
		f_we    = 1'b0;
		f_waddr = mqf_pkg::slot_addr(push_q_s1, wpos);
		f_wdata = word_q;
		f_raddr = mqf_pkg::slot_addr(tgt_idx, cur.head);
		case (state_q)
			mqf_pkg::ST_PUSH: begin
				d_we    = push_v_s1 && sel;
				d_waddr = push_q_s1;
				d_wdata = push_desc;
				f_we    = push_v_s1 && sel;
			end
			mqf_pkg::ST_DESC: begin
				d_we = pop_hit;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mqf_pkg::ST_IDLE;
			rd_q_q      <= '0;
			push_v_s1   <= 1'b0;
			desc_hit_s1 <= 1'b0;
			desc_vld_q  <= '0;
			drop_sum_q  <= '0;
			total_q     <= '0;
			closed_q    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			push_v_s1   <= issue;
			desc_hit_s1 <= desc_vld_q[d_raddr];
			done_q      <= ((state_q == mqf_pkg::ST_DESC) && !pop_hit) ||
				(state_q == mqf_pkg::ST_FRAME);
			if (accept) begin
				rd_q_q     <= '0;
				drop_sum_q <= '0;
				if (mqf_pkg::action_t'(action) == mqf_pkg::ACT_CLOSE) begin
					closed_q <= 1'b1;
				end
			end
			if (issue) begin
				rd_q_q <= rd_q_q + mqf_pkg::CNT_W'(1);
			end
			if (d_we) begin
				desc_vld_q[d_waddr] <= 1'b1;
			end
			if (push_v_s1 && sel) begin
				drop_sum_q <= drop_sum_q + mqf_pkg::SUM_W'(q_drop);
			end
			if (push_end) begin
				total_q <= total_sum[mqf_pkg::TOTAL_W] ? '1 : total_sum[mqf_pkg::TOTAL_W-1:0];
			end
		end
	end

	// Item latch, push stage index and result words.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= mqf_pkg::action_t'(action);
			tgt_q  <= target;
			word_q <= frame_word;
		end
		push_q_s1 <= mqf_pkg::TIDX_W'(rd_q_q);
		if (state_q == mqf_pkg::ST_DESC) begin
			pop_valid_q <= 1'b0;
			frame_out_q <= '0;
			drop_now_q  <= drop_sat;
			if (pop_hit) begin
				depth_q <= mqf_pkg::DEPTH_W'(pop_desc.fill);
			end else if (known) begin
				depth_q <= mqf_pkg::DEPTH_W'(cur.fill);
			end else begin
				depth_q <= '0;
			end
		end
		if (state_q == mqf_pkg::ST_FRAME) begin
			pop_valid_q <= 1'b1;
			frame_out_q <= f_rdata;
		end
	end

	assign busy          = (state_q != mqf_pkg::ST_IDLE);
	assign done          = done_q;
	assign pop_valid     = pop_valid_q;
	assign frame_out     = frame_out_q;
	assign dropped_now   = drop_now_q;
	assign total_dropped = total_q;
	assign target_depth  = depth_q;
	assign closed        = closed_q;

endmodule

// File: rtl/mqf_chk.sv
// Port-level checker of the multi-queue fan-out block and its bind to the top level.
module mqf_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic                            pop_valid,
	input logic [mqf_pkg::FRAME_WIDTH-1:0] frame_out,
	input logic [mqf_pkg::DROP_W-1:0]      dropped_now,
	input logic [mqf_pkg::TOTAL_W-1:0]     total_dropped,
	input logic                            closed
);

	// An accepted word always occupies the sequencer.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");

	// Finishing a word raises the result strobe.
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result without a popped frame reports a zero frame.
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pop_valid |-> frame_out == '0)
		else $error("frame_out nonzero without pop_valid");

	// Drops of this push are part of the running total.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		done && (dropped_now != '0) |-> total_dropped != '0)
		else $error("drops reported but total is zero");

	// Half close only ends with reset.
	a_closed: assert property (@(posedge clk) disable iff (!arst_n)
		closed |=> closed)
		else $error("closed flag cleared without reset");

endmodule

bind multi_queue_fanout_drop_oldest mqf_chk u_chk (.*);
